// ----- sv/sound_peak_burst_detector_core_macros.svh -----
// Assertion helpers for the detector core, the one file that checks itself.
`ifndef SOUND_PEAK_BURST_DETECTOR_CORE_MACROS_SVH
`define SOUND_PEAK_BURST_DETECTOR_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SPBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbl failed");

// Antecedent implies consequent in the next cycle.
`define SPBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

// ----- sv/spbd_pkg.sv -----
package spbd_pkg;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned LVL_BITS  = 10;
  localparam int unsigned MS_BITS   = 16;
  localparam int unsigned SUM_BITS  = 26;
  localparam int unsigned QUIET_MIN = 10;

  localparam logic [2:0] REG_NOISE    = 3'd0;
  localparam logic [2:0] REG_PEAK     = 3'd1;
  localparam logic [2:0] REG_BURST    = 3'd2;
  localparam logic [2:0] REG_PEAK_MIN = 3'd3;
  localparam logic [2:0] REG_COOLDOWN = 3'd4;
  localparam logic [2:0] REG_CALIB    = 3'd5;
  localparam logic [2:0] REG_DRIFT    = 3'd6;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ----- sv/spbd_divider.sv -----
module spbd_divider import spbd_pkg::*; #(
  parameter int unsigned NUM_BITS = 26,
  parameter int unsigned DEN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output div_ctl_t            ctl,
  output logic [NUM_BITS-1:0] quo
);
  localparam int unsigned CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q_r;
  logic [DEN_BITS:0]   rem_r;
  logic [DEN_BITS-1:0] den_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r, done_r;
  logic [DEN_BITS:0]   shifted, diff;

  // One quotient bit per cycle, restoring division.
  assign shifted = {rem_r[DEN_BITS-1:0], q_r[NUM_BITS-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        q_r    <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= CW'(NUM_BITS);
      end else if (busy_r) begin
        if (!diff[DEN_BITS]) begin
          rem_r <= diff;
          q_r   <= {q_r[NUM_BITS-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[NUM_BITS-2:0], 1'b0};
        end
        cnt_r  <= cnt_r - 1'b1;
        busy_r <= (cnt_r != CW'(1));
        done_r <= (cnt_r == CW'(1));
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign ctl = '{start: start, busy: busy_r, done: done_r};
  assign quo = q_r;
endmodule

// ----- sv/sound_peak_burst_detector_core.sv -----
// Sound peak and burst detector.
// The in_ channel carries one item per ADC sample: tdata[9:0] is the sample
// and tdata[41:10] its millisecond timestamp. The out_ channel carries event
// items: tdata[0] kind (0 peak, 1 burst), [10:1] amplitude, [42:11] event
// time; tlast marks the final event caused by one sample.
// A calibration sample passes through S_CAL and a calibrated sample through
// S_DIFF and S_DET. The bit-serial divider makes its quotient one bit per
// cycle and then raises done; the sample that closes the calibration window
// waits for it in S_DIV, and one that triggers a drift correction waits
// there between S_DIFF and S_DET.
// A sample can cause up to two events, delivered one per cycle from the
// output register; while an event waits or the receiver stalls, the block
// holds and takes no new sample. Configuration goes through an APB port,
// register i at 4*i.
// Synchronous active-low reset returns registers to their reset values,
// the baseline to half scale and the detector to the uncalibrated state.
module sound_peak_burst_detector_core import spbd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: sample, now_ms, zero fill.
  input  logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: event_kind, amplitude, event_time, zero fill.
  output logic [((SAMPLE_BITS+TIME_BITS+1+7)/8)*8-1:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned TB = SB + CB;
  localparam int unsigned OW = ((SB + TIME_BITS + 1 + 7) / 8) * 8;
  localparam logic [CB-1:0] CMAX = '1;

  typedef enum logic [2:0] {S_IDLE, S_CAL, S_DIFF, S_DIV, S_DET, S_OUT} state_t;

  logic [LVL_BITS-1:0] noise_r, peakl_r, burstl_r;
  logic [MS_BITS-1:0]  pmin_r, cool_r, calw_r, drift_r;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= 10'd10; peakl_r <= 10'd25; burstl_r <= 10'd250;
      pmin_r <= 16'd20; cool_r <= 16'd600; calw_r <= 16'd1500; drift_r <= 16'd5000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[4:2])
        REG_NOISE:    noise_r  <= cfg_pwdata[LVL_BITS-1:0];
        REG_PEAK:     peakl_r  <= cfg_pwdata[LVL_BITS-1:0];
        REG_BURST:    burstl_r <= cfg_pwdata[LVL_BITS-1:0];
        REG_PEAK_MIN: pmin_r   <= cfg_pwdata[MS_BITS-1:0];
        REG_COOLDOWN: cool_r   <= cfg_pwdata[MS_BITS-1:0];
        REG_CALIB:    calw_r   <= cfg_pwdata[MS_BITS-1:0];
        REG_DRIFT:    drift_r  <= cfg_pwdata[MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[4:2])
      REG_NOISE:    cfg_prdata = 32'(noise_r);
      REG_PEAK:     cfg_prdata = 32'(peakl_r);
      REG_BURST:    cfg_prdata = 32'(burstl_r);
      REG_PEAK_MIN: cfg_prdata = 32'(pmin_r);
      REG_COOLDOWN: cfg_prdata = 32'(cool_r);
      REG_CALIB:    cfg_prdata = 32'(calw_r);
      REG_DRIFT:    cfg_prdata = 32'(drift_r);
      default:      cfg_prdata = '0;
    endcase
  end

  state_t state_r;
  logic started_r, cal_r, peak_act_r, is_drift_r;
  logic [TIME_BITS-1:0] cal_t0_r, drift_t_r, peak_t0_r, burst_t_r, now_r;
  logic [TB-1:0] cal_sum_r, q_sum_r;
  logic [CB-1:0] cal_n_r, q_n_r;
  logic [SB-1:0] base_r, top_r, s_r;
  logic [TIME_BITS-1:0] el_r;
  logic burst_pend_r;
  logic [OW-1:0] odata_r;
  logic olast_r, ovalid_r;

  // Divider shared by calibration and drift averaging.
  logic div_start;
  logic [TB-1:0] div_num, quo;
  logic [CB-1:0] div_den;
  div_ctl_t dctl;
  spbd_divider #(.NUM_BITS(TB), .DEN_BITS(CB)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den), .ctl(dctl), .quo
  );

  logic [SB-1:0] s_in, dist_in, dev_c, amp_c;
  logic [TIME_BITS-1:0] now_in, el_in;
  logic [SB+1:0] blend;
  assign s_in    = in_tdata[SB-1:0];
  assign now_in  = in_tdata[SB+TIME_BITS-1:SB];
  // Distance of the incoming sample from the baseline; the baseline does not
  // move between acceptance and the drift check, so quiet samples are
  // counted as they arrive.
  assign dist_in = (s_in >= base_r) ? s_in - base_r : base_r - s_in;
  // Elapsed time against the calibration start or the last drift correction.
  assign el_in   = !started_r ? '0 : (cal_r ? now_in - drift_t_r : now_in - cal_t0_r);
  assign dev_c   = (s_r > base_r) ? s_r - base_r : '0;
  assign amp_c   = (dev_c > top_r) ? dev_c : top_r;
  assign blend   = {2'b00, base_r} + {1'b0, base_r, 1'b0} + (SB+2)'(quo[SB-1:0]);

  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  always_comb begin
    div_start = 1'b0;
    div_num   = (state_r == S_DIFF) ? q_sum_r : cal_sum_r;
    div_den   = (state_r == S_DIFF) ? q_n_r : cal_n_r;
    if (state_r == S_CAL && !cal_r && el_r >= TIME_BITS'(calw_r)) div_start = 1'b1;
    if (state_r == S_DIFF && el_r >= TIME_BITS'(drift_r) && q_n_r > CB'(QUIET_MIN))
      div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; started_r <= 1'b0; cal_r <= 1'b0; peak_act_r <= 1'b0;
      cal_t0_r <= '0; drift_t_r <= '0; peak_t0_r <= '0; burst_t_r <= '0;
      cal_sum_r <= '0; q_sum_r <= '0; cal_n_r <= '0; q_n_r <= '0;
      base_r <= SB'(1) << (SB - 1); top_r <= '0;
      ovalid_r <= 1'b0; burst_pend_r <= 1'b0; is_drift_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          // An event only ever waits here, since the input is held meanwhile.
          if (ovalid_r) begin
            if (out_tready) begin
              if (burst_pend_r) begin
                burst_pend_r <= 1'b0;
                odata_r[0] <= 1'b1; olast_r <= 1'b1;
              end else begin
                ovalid_r <= 1'b0;
              end
            end
          end else if (in_tvalid) begin
            s_r <= s_in; now_r <= now_in; el_r <= el_in;
            if (!started_r) begin
              started_r <= 1'b1; cal_t0_r <= now_in;
            end
            if (!cal_r) begin
              if (cal_n_r != CMAX) begin
                cal_sum_r <= cal_sum_r + TB'(s_in);
                cal_n_r   <= cal_n_r + 1'b1;
              end
              state_r <= S_CAL;
            end else begin
              if (dist_in < noise_r && q_n_r != CMAX) begin
                q_sum_r <= q_sum_r + TB'(s_in);
                q_n_r   <= q_n_r + 1'b1;
              end
              state_r <= S_DIFF;
            end
          end
        end
        S_CAL: begin
          is_drift_r <= 1'b0;
          state_r <= div_start ? S_DIV : S_IDLE;
        end
        S_DIFF: begin
          is_drift_r <= 1'b1;
          state_r <= div_start ? S_DIV : S_DET;
        end
        S_DIV: begin
          if (dctl.done) begin
            if (is_drift_r) begin
              base_r <= blend[SB+1:2];
              q_sum_r <= '0; q_n_r <= '0; drift_t_r <= now_r;
              state_r <= S_DET;
            end else begin
              base_r <= quo[SB-1:0];
              cal_r <= 1'b1; drift_t_r <= now_r;
              state_r <= S_IDLE;
            end
          end
        end
        S_DET: begin
          state_r <= S_IDLE;
          if (!peak_act_r) begin
            if (dev_c > SB'(peakl_r)) begin
              peak_act_r <= 1'b1; peak_t0_r <= now_r; top_r <= dev_c;
            end
          end else if (dev_c < SB'(noise_r)) begin
            peak_act_r <= 1'b0; top_r <= '0;
            if (now_r - peak_t0_r >= TIME_BITS'(pmin_r)) begin
              ovalid_r <= 1'b1;
              odata_r <= OW'({now_r, amp_c, 1'b0});
              if (amp_c > SB'(burstl_r) && now_r - burst_t_r > TIME_BITS'(cool_r)) begin
                burst_pend_r <= 1'b1; olast_r <= 1'b0; burst_t_r <= now_r;
              end else begin
                olast_r <= 1'b1;
              end
            end
          end else if (dev_c > top_r) begin
            top_r <= dev_c;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "sound_peak_burst_detector_core_macros.svh"
  `SPBD_ASSERT_IMP(a_no_in_while_out, out_tvalid, !in_tready)
  `SPBD_ASSERT_IMP(a_div_only_in_div, dctl.busy, state_r == S_DIV)
  `SPBD_ASSERT_NXT(a_div_runs, dctl.start, dctl.busy)
  `SPBD_ASSERT_NXT(a_burst_follows, out_tvalid && out_tready && !out_tlast, out_tvalid)
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import spbd_pkg::*;

  // Register index with no register behind it; a write there must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  // Clock cycles before the run is declared hung. About 400 items are sent,
  // the receiver holds off once, and each test ends in a drain.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Quiet cycles allowed after the last event for a divider pass to finish.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CNT_MAX = 16'hFFFF;

  // One detector event as it leaves the out_ channel.
  typedef struct packed {
    logic        kind;
    logic [9:0]  amp;
    logic [31:0] stamp;
    logic        last;
  } evt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // Fields from bit 0: sample, now_ms, zero fill.
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // Fields from bit 0: event_kind, amplitude, event_time, zero fill.
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sound_peak_burst_detector_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow of the detector: register copies and the state that the block
  // keeps from one sample to the next.
  // ---------------------------------------------------------------------
  logic [9:0]  noise_lvl, peak_lvl, burst_lvl;
  logic [15:0] peak_min, cooldown, calib_win, drift_per;
  logic        seen_first, calibrated, peak_on;
  logic [31:0] calib_t0, drift_t0, peak_t0, burst_t0;
  logic [25:0] calib_sum, quiet_sum;
  logic [15:0] calib_cnt, quiet_cnt;
  logic [9:0]  base, top;

  evt_t pending_events[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;

  // Shared by the sender and the receiver: when set, neither side idles.
  bit calm = 1'b0;
  // Raised once by a test; the receiver then holds off on its own count.
  logic hold_go = 1'b0;
  // Running millisecond clock used to build timestamps.
  logic [31:0] now_ms = '0;

  function automatic void clear_shadow();
    noise_lvl = 10'd10;
    peak_lvl = 10'd25;
    burst_lvl = 10'd250;
    peak_min = 16'd20;
    cooldown = 16'd600;
    calib_win = 16'd1500;
    drift_per = 16'd5000;
    seen_first = 1'b0;
    calibrated = 1'b0;
    peak_on = 1'b0;
    calib_t0 = '0;
    drift_t0 = '0;
    peak_t0 = '0;
    burst_t0 = '0;
    calib_sum = '0;
    quiet_sum = '0;
    calib_cnt = '0;
    quiet_cnt = '0;
    base = 10'd512;
    top = '0;
  endfunction

  // Works out the events one accepted sample causes and queues them.
  function automatic void predict_events(logic [9:0] s, logic [31:0] t);
    logic [9:0] spread, dev;
    int unsigned avg;
    logic loud;
    if (!seen_first) begin
      seen_first = 1'b1;
      calib_t0 = t;
    end
    if (!calibrated) begin
      if (calib_cnt < CNT_MAX) begin
        calib_sum = calib_sum + s;
        calib_cnt = calib_cnt + 1;
      end
      if (32'(t - calib_t0) >= calib_win) begin
        base = 10'(calib_sum / calib_cnt);
        calibrated = 1'b1;
        drift_t0 = t;
      end
      return;
    end
    spread = (s >= base) ? s - base : base - s;
    if (spread < noise_lvl && quiet_cnt < CNT_MAX) begin
      quiet_sum = quiet_sum + s;
      quiet_cnt = quiet_cnt + 1;
    end
    // Drift correction moves the baseline a quarter toward the quiet average.
    if (32'(t - drift_t0) >= drift_per && quiet_cnt > QUIET_MIN) begin
      avg = quiet_sum / quiet_cnt;
      base = 10'((base * 3 + avg) / 4);
      quiet_sum = '0;
      quiet_cnt = '0;
      drift_t0 = t;
    end
    dev = (s > base) ? s - base : '0;
    if (!peak_on) begin
      if (dev > peak_lvl) begin
        peak_on = 1'b1;
        peak_t0 = t;
        top = dev;
      end
      return;
    end
    if (dev > top) top = dev;
    if (dev < noise_lvl) begin
      if (32'(t - peak_t0) >= peak_min) begin
        loud = (top > burst_lvl) && (32'(t - burst_t0) > cooldown);
        pending_events.push_back('{kind: 1'b0, amp: top, stamp: t, last: !loud});
        if (loud) begin
          pending_events.push_back('{kind: 1'b1, amp: top, stamp: t, last: 1'b1});
          burst_t0 = t;
        end
      end
      peak_on = 1'b0;
      top = '0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random backpressure, one long hold-off, and the event check.
  // ---------------------------------------------------------------------
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    evt_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tdata[0], amp: out_tdata[10:1], stamp: out_tdata[42:11],
                last: out_tlast};
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected event kind=%0d amp=%0d time=%h last=%0d",
                     got.kind, got.amp, got.stamp, got.last);
        end else begin
          want = pending_events.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"event mismatch: exp kind=%0d amp=%0d time=%h last=%0d,",
                        " got kind=%0d amp=%0d time=%h last=%0d"},
                       want.kind, want.amp, want.stamp, want.last,
                       got.kind, got.amp, got.stamp, got.last);
          end
        end
      end
      // The long hold lets the block fill its output and stall the input.
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) if (in_tvalid && in_tready) sent++;

  // ---------------------------------------------------------------------
  // Shared drivers.
  // ---------------------------------------------------------------------

  // Offers one sample and returns at the edge that accepts it. Valid stays
  // high afterwards so that back-to-back items need no second assignment in
  // the same step; an idle gap or stop_input lowers it.
  task automatic send_sample(input logic [9:0] s, input logic [31:0] t);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 37) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, t, s};
    do @(posedge clk); while (!in_tready);
    predict_events(s, t);
  endtask

  task automatic stop_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected event has arrived, then lets a divider pass
  // that causes no event run out before anything else happens.
  task automatic drain();
    stop_input();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_NOISE:    noise_lvl = val[9:0];
      REG_PEAK:     peak_lvl = val[9:0];
      REG_BURST:    burst_lvl = val[9:0];
      REG_PEAK_MIN: peak_min = val[15:0];
      REG_COOLDOWN: cooldown = val[15:0];
      REG_CALIB:    calib_win = val[15:0];
      REG_DRIFT:    drift_per = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_levels(input logic [31:0] nz, input logic [31:0] pk,
                            input logic [31:0] bu, input logic [31:0] mn,
                            input logic [31:0] cd, input logic [31:0] dr);
    write_reg(REG_NOISE, nz);
    write_reg(REG_PEAK, pk);
    write_reg(REG_BURST, bu);
    write_reg(REG_PEAK_MIN, mn);
    write_reg(REG_COOLDOWN, cd);
    write_reg(REG_DRIFT, dr);
  endtask

  // Level relative to the current baseline, kept inside the ADC range.
  function automatic logic [9:0] near_base(int offset);
    int v;
    v = int'(base) + offset;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  task automatic tick_send(input int offset, input int unsigned step);
    now_ms = now_ms + step;
    send_sample(near_base(offset), now_ms);
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // The first sample opens calibration with the timestamp near the top of
  // the 32-bit range; the longest window closes after the timestamp wraps.
  task automatic test_calibration_wrap();
    calm = 1'b1;
    write_reg(REG_CALIB, 32'h0000_FFFF);
    now_ms = 32'hFFFF_8000;
    send_sample(10'd0, now_ms);
    send_sample(10'd1023, now_ms);
    repeat (26) send_sample(10'($urandom_range(300, 700)), now_ms);
    now_ms = now_ms + 32'h0000_FFFF;
    send_sample(10'($urandom_range(0, 1023)), now_ms);
    drain();
    calm = 1'b0;
  endtask

  // Hand-built peaks: extremes of the sample, a burst, a second burst after
  // the cooldown, a peak too short to report, a peak ending just under the
  // noise level and a peak across the wrap of the timestamp.
  task automatic test_directed_peaks();
    set_levels(10, 25, 250, 20, 600, 5000);
    now_ms = now_ms + 32'd1000;
    tick_send(0, 5);
    tick_send(1023, 5);
    tick_send(1023, 10);
    tick_send(0, 10);
    tick_send(300, 5);
    tick_send(0, 30);
    tick_send(300, 700);
    tick_send(-1023, 25);
    tick_send(100, 1);
    tick_send(0, 1);
    tick_send(26, 3);
    tick_send(200, 5);
    tick_send(9, 20);
    now_ms = 32'hFFFF_FFF0;
    tick_send(400, 8);
    tick_send(0, 24);
    drain();
  endtask

  // Every sample counts as quiet while the longest drift period runs; the
  // last sample then applies the drift toward the quiet average.
  task automatic test_quiet_drift();
    calm = 1'b1;
    set_levels(1023, 1023, 250, 20, 600, 32'h0000_FFFF);
    now_ms = now_ms + 32'd70000;
    send_sample(base, now_ms);
    repeat (30) send_sample(near_base($urandom_range(0, 600) - 300), now_ms);
    now_ms = now_ms + 32'h0000_FFFF;
    send_sample(base, now_ms);
    drain();
    calm = 1'b0;
  endtask

  // One random run: quiet samples, a rise of random length and height, and
  // an end; some items are plain noise with random time jumps.
  task automatic random_run();
    int unsigned n;
    if ($urandom_range(99) < 15) begin
      if ($urandom_range(3) == 0) now_ms = $urandom;
      else now_ms = now_ms + $urandom_range(0, 2000);
      send_sample(10'($urandom_range(0, 1023)), now_ms);
      return;
    end
    n = $urandom_range(0, 14);
    repeat (n) tick_send($urandom_range(0, 2 * noise_lvl) - int'(noise_lvl), $urandom_range(1, 40));
    n = $urandom_range(1, 5);
    repeat (n) tick_send(int'(peak_lvl) + $urandom_range(1, 500), $urandom_range(0, 15));
    tick_send($urandom_range(0, noise_lvl) - 2, $urandom_range(0, 40));
  endtask

  task automatic random_phase(input int unsigned items, input int unsigned calm_items);
    int unsigned start;
    start = sent;
    calm = 1'b1;
    while (sent - start < items) begin
      if (sent - start >= calm_items) calm = 1'b0;
      random_run();
    end
    calm = 1'b0;
    drain();
  endtask

  // Random runs at reset levels but a short drift period; no idling at first.
  task automatic test_random_nominal();
    set_levels(10, 25, 250, 20, 600, 300);
    random_phase(110, 50);
  endtask

  // Lowest thresholds and times, top noise level: nearly every sample starts
  // or ends a peak. One write is wider than its register, one hits none.
  task automatic test_random_low_extremes();
    set_levels(32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    write_reg(REG_CALIB, 0);
    write_reg(REG_UNUSED, 32'h0000_0155);
    random_phase(70, 0);
  endtask

  // Highest levels and times but zero noise: peaks cannot start, no drift.
  task automatic test_random_high_extremes();
    set_levels(0, 1023, 1023, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    random_phase(30, 0);
  endtask

  // Frequent short peaks while the receiver stops for a long stretch.
  task automatic test_output_backpressure();
    set_levels(40, 60, 300, 5, 100, 1000);
    hold_go <= 1'b1;
    random_phase(90, 0);
  endtask

  initial begin
    clear_shadow();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_calibration_wrap();
    test_directed_peaks();
    test_quiet_drift();
    test_random_nominal();
    test_random_low_extremes();
    test_random_high_extremes();
    test_output_backpressure();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/spbd_pkg.sv
sv/spbd_divider.sv
sv/sound_peak_burst_detector_core.sv
dv/tb_top.sv
